FILE: design/assert_macros.svh
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and held off while arst_n is low.
`define ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("timer queue check failed");

// Next-cycle implication, sampled on clk and held off while arst_n is low.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("timer queue check failed");

`endif

FILE: design/mhts_pkg.sv
// ----------------------------------------------------------------------------
// mhts_pkg
// Types, codes and helper functions of the min-heap timer scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mhts_pkg;

	localparam int SLOTS_DEF   = 256;
	localparam int SLOT_FLD_W  = 16;
	localparam int SEQ_W       = 15;
	localparam int TIME_W      = 48;
	localparam int VAL_W       = 31;

	localparam logic [1:0] FN_START    = 2'd0;
	localparam logic [1:0] FN_STOP     = 2'd1;
	localparam logic [1:0] FN_TICK     = 2'd2;
	localparam logic [1:0] FN_COMPLETE = 2'd3;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_NO_SPACE    = 3'd1;
	localparam logic [2:0] ST_RANGE       = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND   = 3'd3;
	localparam logic [2:0] ST_BUSY        = 3'd4;
	localparam logic [2:0] ST_NOT_DUE     = 3'd5;
	localparam logic [2:0] ST_NOT_RUNNING = 3'd6;

	typedef struct packed {
		logic [1:0]        func;
		logic [TIME_W-1:0] now_ms;
		logic [VAL_W-1:0]  delay_ms;
		logic              disable_req;
		logic [VAL_W-1:0]  handle_in;
	} cmd_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [VAL_W-1:0] handle_out;
		logic [VAL_W-1:0] left_ms;
		logic             fired;
	} rsp_t;

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_START1, S_START2, S_STOP1, S_STOP2,
		S_TICK1, S_TICK2, S_COMP1, S_COMP2, S_REM, S_REM1, S_REM2,
		S_UP, S_UP1, S_UP2, S_DOWN, S_D1, S_D2, S_D3, S_D4, S_PLACE, S_RESP
	} state_t;

	// Deadline of now plus delay, saturated at the top of the time range.
	function automatic logic [TIME_W-1:0] sat_add48(input logic [TIME_W-1:0] now,
			input logic [VAL_W-1:0] dly);
		logic [TIME_W:0] sum;
		sum = {1'b0, now} + {{(TIME_W + 1 - VAL_W){1'b0}}, dly};
		return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
	endfunction

	// Time left before a deadline, floored at zero and saturated to 31 bits.
	function automatic logic [VAL_W-1:0] time_left(input logic [TIME_W-1:0] dl,
			input logic [TIME_W-1:0] now);
		logic [TIME_W-1:0] diff;
		diff = dl - now;
		if (dl <= now)
			return '0;
		if (diff[TIME_W-1:VAL_W] != '0)
			return {VAL_W{1'b1}};
		return diff[VAL_W-1:0];
	endfunction

endpackage

FILE: design/mhts_ram.sv
// ----------------------------------------------------------------------------
// mhts_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mhts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

FILE: design/min_heap_timer_scheduler_top.sv
// ----------------------------------------------------------------------------
// min_heap_timer_scheduler_top
// Timer queue kept as a binary min-heap of deadlines in on-chip RAM.
// ----------------------------------------------------------------------------
//
//  channel  | ports                 | transfer rule
//  ---------+-----------------------+--------------------------------------
//  command  | start, busy, cmd      | taken at a clock edge with start & !busy
//  response | done, rsp             | valid for one cycle while done is high
//
// Every transaction gives exactly one response. A start climbs heap levels
// from the new leaf; a stop or a complete may also walk down the heap.
// Each memory has a single read port, so every heap level needs a slot read
// and then a deadline read. After reset the block sweeps the order,
// position and sequence memories, one entry per cycle, with busy high.
// The receiver cannot stall.
`timescale 1ns / 1ps

module min_heap_timer_scheduler_top
	import mhts_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cmd_t cmd,
	output logic done,
	output rsp_t rsp
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam int XW = IW + 2;

	state_t state_q, state_d;

	// Control state.
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic [IW-1:0] run_slot_q;
	logic [IW-1:0] clr_q;

	// Working registers of the current transaction.
	cmd_t              item_q;
	rsp_t              res_q;
	logic [IW-1:0]     p_q, pos_q, rem_slot_q, mov_slot_q;
	logic [IW-1:0]     ps_q, ls_q, rs_q, cs_q, c_q;
	logic [TIME_W-1:0] mov_key_q, lk_q, ck_q;
	logic              down_en_q, moved_q;

	// Memory ports: heap order, deadline, heap position, sequence.
	logic              o_we, h_we, d_we, s_we;
	logic [IW-1:0]     o_waddr, o_wdata, o_raddr, o_rdata;
	logic [IW-1:0]     h_waddr, h_wdata, h_raddr, h_rdata;
	logic [IW-1:0]     d_waddr, d_raddr;
	logic [TIME_W-1:0] d_wdata, d_rdata;
	logic [IW-1:0]     s_waddr, s_raddr;
	logic [SEQ_W-1:0]  s_wdata, s_rdata;

	mhts_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_order (
		.clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
		.raddr(o_raddr), .rdata(o_rdata));
	mhts_ram #(.WIDTH(IW), .DEPTH(SLOTS)) u_pos (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.raddr(h_raddr), .rdata(h_rdata));
	mhts_ram #(.WIDTH(TIME_W), .DEPTH(SLOTS)) u_deadline (
		.clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
		.raddr(d_raddr), .rdata(d_rdata));
	mhts_ram #(.WIDTH(SEQ_W), .DEPTH(SLOTS)) u_seq (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.raddr(s_raddr), .rdata(s_rdata));

	// Derived values.
	logic              accept;
	logic [IW-1:0]     parent, stop_slot;
	logic [XW-1:0]     l_x, r_x, cnt_x;
	logic              l_ok, r_ok, pos_in, stop_go, up_less, cmd_range_bad;
	logic              rcmp_right;
	logic [TIME_W-1:0] new_dl;

	assign busy     = (state_q != S_IDLE);
	assign accept   = start && !busy;
	assign done     = (state_q == S_RESP);
	assign rsp      = res_q;

	assign parent    = (p_q - IW'(1)) >> 1;
	assign l_x       = {1'b0, p_q, 1'b1};
	assign r_x       = l_x + XW'(1);
	assign cnt_x     = XW'(cnt_q);
	assign l_ok      = l_x < cnt_x;
	assign r_ok      = r_x < cnt_x;
	assign pos_in    = XW'(h_rdata) < cnt_x;
	assign stop_slot = item_q.handle_in[IW-1:0];
	assign new_dl    = sat_add48(item_q.now_ms, item_q.delay_ms);
	assign up_less   = mov_key_q < d_rdata;
	assign rcmp_right = !(lk_q < d_rdata);
	assign cmd_range_bad = {1'b0, cmd.handle_in[SLOT_FLD_W-1:0]} >= (SLOT_FLD_W + 1)'(SLOTS);

	// A stop goes ahead when the handle matches a live slot that is not running.
	assign stop_go = (s_rdata == item_q.handle_in[VAL_W-1:SLOT_FLD_W]) && pos_in &&
		!(run_q && (run_slot_q == stop_slot));

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR:  if (clr_q == IW'(SLOTS - 1)) state_d = S_IDLE;
			S_IDLE: begin
				if (accept) begin
					unique case (cmd.func)
						FN_START:    state_d = (cnt_q >= CW'(SLOTS)) ? S_RESP : S_START1;
						FN_STOP:     state_d = cmd_range_bad ? S_RESP : S_STOP1;
						FN_TICK:     state_d = (run_q || cnt_q == '0) ? S_RESP : S_TICK1;
						FN_COMPLETE: state_d = run_q ? S_COMP1 : S_RESP;
					endcase
				end
			end
			S_START1: state_d = S_START2;
			S_START2: state_d = S_UP;
			S_STOP1:  state_d = stop_go ? S_STOP2 : S_RESP;
			S_STOP2:  state_d = S_REM;
			S_REM:    state_d = S_REM1;
			S_REM1:   state_d = (XW'(pos_q) < cnt_x) ? S_REM2 : S_RESP;
			S_REM2:   state_d = S_UP;
			S_TICK1:  state_d = S_TICK2;
			S_TICK2:  state_d = S_RESP;
			S_COMP1: begin
				if (!pos_in)
					state_d = S_RESP;
				else if (item_q.disable_req)
					state_d = S_COMP2;
				else
					state_d = S_UP;
			end
			S_COMP2:  state_d = S_REM;
			S_UP: begin
				if (p_q != '0)
					state_d = S_UP1;
				else
					state_d = (down_en_q && !moved_q) ? S_DOWN : S_PLACE;
			end
			S_UP1:    state_d = S_UP2;
			S_UP2: begin
				if (up_less)
					state_d = S_UP;
				else
					state_d = (down_en_q && !moved_q) ? S_DOWN : S_PLACE;
			end
			S_DOWN:   state_d = l_ok ? S_D1 : S_PLACE;
			S_D1:     state_d = S_D2;
			S_D2:     state_d = r_ok ? S_D3 : S_D4;
			S_D3:     state_d = S_D4;
			S_D4:     state_d = (ck_q > mov_key_q) ? S_PLACE : S_DOWN;
			S_PLACE:  state_d = S_RESP;
			S_RESP:   state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// Memory controls.
	always_comb begin
		o_we = 1'b0; o_waddr = '0; o_wdata = '0; o_raddr = '0;
		h_we = 1'b0; h_waddr = '0; h_wdata = '0; h_raddr = '0;
		d_we = 1'b0; d_waddr = '0; d_wdata = '0; d_raddr = '0;
		s_we = 1'b0; s_waddr = '0; s_wdata = '0; s_raddr = '0;
		unique case (state_q)
			S_CLEAR: begin
				o_we = 1'b1; o_waddr = clr_q; o_wdata = clr_q;
				h_we = 1'b1; h_waddr = clr_q; h_wdata = clr_q;
				s_we = 1'b1; s_waddr = clr_q;
			end
			S_IDLE: begin
				o_raddr = (cmd.func == FN_START) ? cnt_q[IW-1:0] : '0;
				h_raddr = (cmd.func == FN_STOP) ? cmd.handle_in[IW-1:0] : run_slot_q;
				s_raddr = h_raddr;
			end
			S_START1: begin
				d_we = 1'b1; d_waddr = o_rdata; d_wdata = new_dl;
				h_we = 1'b1; h_waddr = o_rdata; h_wdata = cnt_q[IW-1:0];
				s_raddr = o_rdata;
			end
			S_STOP1: begin
				if (stop_go) begin
					s_we = 1'b1; s_waddr = stop_slot; s_wdata = s_rdata + SEQ_W'(1);
				end
				d_raddr = stop_slot;
			end
			S_REM:   o_raddr = cnt_q[IW-1:0] - IW'(1);
			S_REM1: begin
				o_we = 1'b1; o_waddr = cnt_q[IW-1:0]; o_wdata = rem_slot_q;
				h_we = 1'b1; h_waddr = rem_slot_q; h_wdata = cnt_q[IW-1:0];
				d_raddr = o_rdata;
			end
			S_TICK1: begin
				d_raddr = o_rdata;
				s_raddr = o_rdata;
			end
			S_COMP1: begin
				s_raddr = run_slot_q;
				if (pos_in && !item_q.disable_req) begin
					d_we = 1'b1; d_waddr = run_slot_q; d_wdata = new_dl;
				end
			end
			S_COMP2: begin
				s_we = 1'b1; s_waddr = run_slot_q; s_wdata = s_rdata + SEQ_W'(1);
			end
			S_UP:    o_raddr = parent;
			S_UP1:   d_raddr = o_rdata;
			S_UP2: begin
				if (up_less) begin
					o_we = 1'b1; o_waddr = p_q; o_wdata = ps_q;
					h_we = 1'b1; h_waddr = ps_q; h_wdata = p_q;
				end
			end
			S_DOWN:  o_raddr = l_x[IW-1:0];
			S_D1: begin
				d_raddr = o_rdata;
				o_raddr = r_x[IW-1:0];
			end
			S_D2:    d_raddr = o_rdata;
			S_D4: begin
				if (!(ck_q > mov_key_q)) begin
					o_we = 1'b1; o_waddr = p_q; o_wdata = cs_q;
					h_we = 1'b1; h_waddr = cs_q; h_wdata = p_q;
				end
			end
			S_PLACE: begin
				o_we = 1'b1; o_waddr = p_q; o_wdata = mov_slot_q;
				h_we = 1'b1; h_waddr = mov_slot_q; h_wdata = p_q;
			end
			default: ;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			cnt_q      <= '0;
			run_q      <= 1'b0;
			run_slot_q <= '0;
			clr_q      <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR)
				clr_q <= clr_q + IW'(1);
			if (accept && cmd.func == FN_COMPLETE)
				run_q <= 1'b0;
			if (state_q == S_START1)
				cnt_q <= cnt_q + CW'(1);
			if (state_q == S_REM)
				cnt_q <= cnt_q - CW'(1);
			if (state_q == S_TICK2 && !(d_rdata > item_q.now_ms)) begin
				run_q      <= 1'b1;
				run_slot_q <= mov_slot_q;
			end
		end
	end

	// Working registers; they carry payload only and need no reset.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					item_q <= cmd;
					res_q  <= '0;
					unique case (cmd.func)
						FN_START: if (cnt_q >= CW'(SLOTS)) res_q.status <= ST_NO_SPACE;
						FN_STOP:  if (cmd_range_bad) res_q.status <= ST_RANGE;
						FN_TICK: begin
							if (run_q)
								res_q.status <= ST_BUSY;
							else if (cnt_q == '0)
								res_q.status <= ST_NOT_DUE;
						end
						FN_COMPLETE: if (!run_q) res_q.status <= ST_NOT_RUNNING;
					endcase
				end
			end
			S_START1: begin
				p_q        <= cnt_q[IW-1:0];
				mov_slot_q <= o_rdata;
				mov_key_q  <= new_dl;
				down_en_q  <= 1'b0;
				moved_q    <= 1'b0;
			end
			S_START2: res_q.handle_out <= {s_rdata, SLOT_FLD_W'(mov_slot_q)};
			S_STOP1: begin
				pos_q      <= h_rdata;
				rem_slot_q <= stop_slot;
				if (!stop_go) begin
					if ((s_rdata != item_q.handle_in[VAL_W-1:SLOT_FLD_W]) || !pos_in)
						res_q.status <= ST_NOT_FOUND;
					else
						res_q.status <= ST_BUSY;
				end
			end
			S_STOP2: res_q.left_ms <= time_left(d_rdata, item_q.now_ms);
			S_REM1: begin
				mov_slot_q <= o_rdata;
				p_q        <= pos_q;
			end
			S_REM2: begin
				mov_key_q <= d_rdata;
				down_en_q <= 1'b1;
				moved_q   <= 1'b0;
			end
			S_TICK1: mov_slot_q <= o_rdata;
			S_TICK2: begin
				if (d_rdata > item_q.now_ms) begin
					res_q.status <= ST_NOT_DUE;
				end else begin
					res_q.handle_out <= {s_rdata, SLOT_FLD_W'(mov_slot_q)};
					res_q.fired      <= 1'b1;
				end
			end
			S_COMP1: begin
				pos_q      <= h_rdata;
				rem_slot_q <= run_slot_q;
				p_q        <= h_rdata;
				mov_slot_q <= run_slot_q;
				mov_key_q  <= new_dl;
				down_en_q  <= 1'b1;
				moved_q    <= 1'b0;
			end
			S_UP1: ps_q <= o_rdata;
			S_UP2: begin
				if (up_less) begin
					p_q     <= parent;
					moved_q <= 1'b1;
				end
			end
			S_D1: ls_q <= o_rdata;
			S_D2: begin
				lk_q <= d_rdata;
				rs_q <= o_rdata;
				if (!r_ok) begin
					c_q  <= l_x[IW-1:0];
					cs_q <= ls_q;
					ck_q <= d_rdata;
				end
			end
			S_D3: begin
				// Ties between the children go to the right one.
				if (rcmp_right) begin
					c_q  <= r_x[IW-1:0];
					cs_q <= rs_q;
					ck_q <= d_rdata;
				end else begin
					c_q  <= l_x[IW-1:0];
					cs_q <= ls_q;
					ck_q <= lk_q;
				end
			end
			S_D4: if (!(ck_q > mov_key_q)) p_q <= c_q;
			default: ;
		endcase
	end

endmodule

FILE: design/mhts_chk.sv
// ----------------------------------------------------------------------------
// mhts_chk
// Port-level checks of the timer scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mhts_chk
	import mhts_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input cmd_t cmd,
	input logic done,
	input rsp_t rsp
);

	`ASSERT_IMPLY(a_done_busy, done, busy)
	`ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	`ASSERT_NEXT(a_done_pulse, done, !done)
	`ASSERT_IMPLY(a_fired_ok, done && rsp.fired, rsp.status == ST_OK)
	`ASSERT_IMPLY(a_err_clean, done && rsp.status != ST_OK, rsp.handle_out == '0 && rsp.left_ms == '0)

endmodule

bind min_heap_timer_scheduler_top mhts_chk u_chk (.*);
